>>> design/bfs_pkg.sv
package bfs_pkg;

    // Number of debounced buttons: stop, mode and fill.
    localparam int BUTTON_COUNT = 3;

    // Widths of the stream payloads.
    localparam int TIME_W        = 32;
    localparam int COUNT_W       = 32;
    localparam int LIMIT_W       = 16;
    localparam int S_TDATA_W     = 72;
    localparam int M_TDATA_W     = 40;

    // Reset values.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(5);
    localparam logic [TIME_W-1:0]  STAMP_RESET  = TIME_W'(20);
    localparam logic [COUNT_W-1:0] TARGET_RESET = COUNT_W'(2528);

    // Operating modes of the sequencer; the code 7 is never entered.
    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_FLOW     = 3'd1,
        MODE_FILL     = 3'd2,
        MODE_FILLMENU = 3'd3,
        MODE_PROGMENU = 3'd4,
        MODE_PROG     = 3'd5,
        MODE_WAIT     = 3'd6
    } mode_t;

    // Button indexes, also used to name the button held in release wait.
    typedef enum logic [1:0] {
        BTN_STOP = 2'd0,
        BTN_MODE = 2'd1,
        BTN_FILL = 2'd2
    } btn_t;

    // Debounced button levels after the current tick.
    typedef struct packed {
        logic fill;
        logic mode;
        logic stop;
    } buttons_t;

    // One result of the sequencer.
    typedef struct packed {
        logic [COUNT_W-1:0] target_count;
        mode_t              mode_code;
        logic               restart_flow;
        logic               pump_on;
    } result_t;

endpackage

>>> design/bfs_debounce.sv
module bfs_debounce (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic                         level,
    input  logic [bfs_pkg::TIME_W-1:0]   now,
    input  logic [bfs_pkg::LIMIT_W-1:0]  limit,
    output logic                         stable_next
);
    import bfs_pkg::*;

    logic              raw_reg;
    logic              stable_reg;
    logic [TIME_W-1:0] stamp_reg;

    logic              changed;
    logic [TIME_W-1:0] elapsed;

    // A change of the raw level restarts the timer and keeps the stable level on that tick.
    // A timestamp behind the stamp is taken as a wrap and counts twice the gap.
    always_comb begin
        changed = (level != raw_reg);
        if (now < stamp_reg) begin
            elapsed = (stamp_reg - now) << 1;
        end else begin
            elapsed = now - stamp_reg;
        end
        stable_next = stable_reg;
        if (!changed && (elapsed > TIME_W'(limit))) begin
            stable_next = level;
        end
    end

    // Button state advances once per processed tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg    <= 1'b0;
            stable_reg <= 1'b0;
            stamp_reg  <= STAMP_RESET;
        end else if (step) begin
            raw_reg    <= level;
            stable_reg <= stable_next;
            if (changed) begin
                stamp_reg <= now;
            end
        end
    end

endmodule

>>> design/bfs_ctrl.sv
module bfs_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  bfs_pkg::buttons_t            btn,
    input  logic [bfs_pkg::COUNT_W-1:0]  flow_count,
    output bfs_pkg::result_t             result,
    output bfs_pkg::mode_t               mode_cur
);
    import bfs_pkg::*;

    mode_t              mode_reg, mode_next;
    mode_t              prior_reg, prior_next;
    mode_t              after_reg, after_next;
    btn_t               held_reg, held_next;
    logic [COUNT_W-1:0] target_reg, target_next;

    logic               entry;
    logic               restart;
    logic               held_level;
    logic [COUNT_W-1:0] count;

    assign mode_cur = mode_reg;

    // State registers advance once per processed tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            prior_reg  <= MODE_WAIT;
            after_reg  <= MODE_IDLE;
            held_reg   <= BTN_STOP;
            target_reg <= TARGET_RESET;
        end else if (step) begin
            mode_reg   <= mode_next;
            prior_reg  <= prior_next;
            after_reg  <= after_next;
            held_reg   <= held_next;
            target_reg <= target_next;
        end
    end

    // Next state: later rules override earlier ones, so stop has the last word.
    always_comb begin
        mode_next   = mode_reg;
        prior_next  = prior_reg;
        after_next  = after_reg;
        held_next   = held_reg;
        target_next = target_reg;
        restart     = 1'b0;
        entry       = (mode_reg != prior_reg);
        count       = entry ? '0 : flow_count;

        unique case (held_reg)
            BTN_STOP: held_level = btn.stop;
            BTN_MODE: held_level = btn.mode;
            BTN_FILL: held_level = btn.fill;
            default:  held_level = 1'b0;
        endcase

        unique case (mode_reg)
            MODE_IDLE: begin
                if (btn.mode) begin
                    after_next = MODE_FILLMENU;
                    held_next  = BTN_MODE;
                    mode_next  = MODE_WAIT;
                end
                if (btn.fill) begin
                    after_next = MODE_FLOW;
                    held_next  = BTN_FILL;
                    mode_next  = MODE_WAIT;
                end
            end
            MODE_FLOW: begin
                if (entry) begin
                    prior_next = mode_reg;
                    restart    = 1'b1;
                end
                if (btn.stop) begin
                    after_next = MODE_IDLE;
                    held_next  = BTN_STOP;
                    mode_next  = MODE_WAIT;
                end
            end
            MODE_FILL: begin
                if (entry) begin
                    prior_next = mode_reg;
                    restart    = 1'b1;
                end
                if (count > target_reg) begin
                    mode_next = MODE_FILLMENU;
                end
                if (btn.stop) begin
                    after_next = MODE_IDLE;
                    held_next  = BTN_STOP;
                    mode_next  = MODE_WAIT;
                end
            end
            MODE_FILLMENU: begin
                if (entry) begin
                    prior_next = mode_reg;
                end
                if (btn.mode) begin
                    after_next = MODE_PROGMENU;
                    held_next  = BTN_MODE;
                    mode_next  = MODE_WAIT;
                end
                if (btn.fill) begin
                    after_next = MODE_FILL;
                    held_next  = BTN_FILL;
                    mode_next  = MODE_WAIT;
                end
                if (btn.stop) begin
                    after_next = MODE_IDLE;
                    held_next  = BTN_STOP;
                    mode_next  = MODE_WAIT;
                end
            end
            MODE_PROGMENU: begin
                if (entry) begin
                    prior_next = mode_reg;
                end
                if (btn.mode) begin
                    after_next = MODE_FILLMENU;
                    held_next  = BTN_MODE;
                    mode_next  = MODE_WAIT;
                end
                if (btn.fill) begin
                    after_next = MODE_PROG;
                    held_next  = BTN_FILL;
                    mode_next  = MODE_WAIT;
                end
                if (btn.stop) begin
                    after_next = MODE_IDLE;
                    held_next  = BTN_STOP;
                    mode_next  = MODE_WAIT;
                end
            end
            MODE_PROG: begin
                if (entry) begin
                    prior_next = mode_reg;
                    restart    = 1'b1;
                end
                if (btn.stop) begin
                    target_next = count;
                    after_next  = MODE_PROGMENU;
                    held_next   = BTN_STOP;
                    mode_next   = MODE_WAIT;
                end
            end
            MODE_WAIT: begin
                if (!held_level) begin
                    mode_next  = after_reg;
                    prior_next = MODE_WAIT;
                end
            end
            default: begin
            end
        endcase

        // The pump runs while a flow state keeps going through this tick.
        result.pump_on      = ((mode_reg == MODE_FLOW) || (mode_reg == MODE_FILL) ||
                               (mode_reg == MODE_PROG)) && (mode_next == mode_reg);
        result.restart_flow = restart;
        result.mode_code    = mode_next;
        result.target_count = target_next;
    end

endmodule

>>> design/bottle_fill_sequencer.sv
// Bottle fill sequencer: one input transfer is one tick carrying the raw stop, mode and
// fill button levels, the keypress timer and the flow pulse count; every tick yields one
// result transfer with the pump drive, the flow restart pulse, the new mode and the fill
// target. The block takes one tick per clock cycle; a result is offered on m_tvalid from
// the result register once its tick has left the input register; only m_tready held low
// slows the flow. The button debouncers and the mode machine lie between the input and
// result registers and advance with each tick. The user must write the debounce limit
// through cfg_we and cfg_wdata only while no ticks are in flight; this is not enforced.
module bottle_fill_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Debounce limit write port.
    input  logic                            cfg_we,
    input  logic [bfs_pkg::LIMIT_W-1:0]     cfg_wdata,
    // Tick input.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // From bit 0: stop_level, mode_level, fill_level, key_time[31:0],
    // flow_count[31:0], zero padding.
    input  logic [bfs_pkg::S_TDATA_W-1:0]   s_tdata,
    // Result output.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // From bit 0: pump_on, restart_flow, mode_code[2:0], target_count[31:0],
    // zero padding.
    output logic [bfs_pkg::M_TDATA_W-1:0]   m_tdata
);
    import bfs_pkg::*;

    logic                  in_valid_reg;
    logic [S_TDATA_W-1:0]  in_data_reg;
    logic                  out_valid_reg;
    result_t               out_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    logic                  advance;
    logic                  step;
    logic [BUTTON_COUNT-1:0] stable;
    buttons_t              btn;
    result_t               result;
    mode_t                 mode_cur;

    // Pipeline control: the result register frees up when empty or taken.
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_reg};

    // Debounce limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    // One debouncer per button.
    for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_button
        bfs_debounce u_debounce (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .step        (step),
            .level       (in_data_reg[i]),
            .now         (in_data_reg[BUTTON_COUNT +: TIME_W]),
            .limit       (limit_reg),
            .stable_next (stable[i])
        );
    end

    assign btn.stop = stable[BTN_STOP];
    assign btn.mode = stable[BTN_MODE];
    assign btn.fill = stable[BTN_FILL];

    // Mode machine and fill target.
    bfs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .btn        (btn),
        .flow_count (in_data_reg[BUTTON_COUNT + TIME_W +: COUNT_W]),
        .result     (result),
        .mode_cur   (mode_cur)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

`ifndef NO_ASSERTIONS
    // A pump-on result always reports a flow mode.
    a_pump_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.pump_on) |->
        ((out_reg.mode_code == MODE_FLOW) || (out_reg.mode_code == MODE_FILL) ||
         (out_reg.mode_code == MODE_PROG)))
        else $error("pump on outside a flow mode");

    // A held tick stays in the input register until the result side frees up.
    a_hold_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("stalled tick lost or changed");

    // The fill target only changes while in program mode.
    a_target_prog: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (mode_cur != MODE_PROG)) |->
        (result.target_count == u_ctrl.target_reg))
        else $error("fill target changed outside program mode");
`endif

endmodule

>>> test/bottle_fill_sequencer_tb.sv
module bottle_fill_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfs_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int PRINT_LIMIT = 50;

    // Raw button level patterns: bit 0 stop, bit 1 mode, bit 2 fill.
    localparam logic [2:0] LV_NONE = 3'b000;
    localparam logic [2:0] LV_STOP = 3'b001;
    localparam logic [2:0] LV_MODE = 3'b010;
    localparam logic [2:0] LV_FILL = 3'b100;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [LIMIT_W-1:0]     cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // Stimulus control shared by the test tasks and the receiver.
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_request = 0;
    int           hold_left = 0;
    int           ticks_sent = 0;
    int           results_checked = 0;
    int           error_count = 0;
    int           cycle_count = 0;
    logic [31:0]  key_clock = '0;

    // Expected results, oldest first.
    result_t      pending_results[$];

    // Predicted sequencer state.
    logic [LIMIT_W-1:0] db_limit;
    logic [2:0]         raw_lvl;
    logic [2:0]         deb_lvl;
    logic [TIME_W-1:0]  change_time[BUTTON_COUNT];
    mode_t              seq_mode;
    mode_t              seq_prior;
    mode_t              seq_after_release;
    btn_t               seq_held;
    logic [COUNT_W-1:0] seq_target;

    bottle_fill_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result receiver: a requested hold-off wins over the random stalls.
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR: %s", msg);
        error_count++;
    endtask

    task automatic reset_sequencer_model();
        int b;
        db_limit = LIMIT_RESET;
        raw_lvl = '0;
        deb_lvl = '0;
        for (b = 0; b < BUTTON_COUNT; b++)
            change_time[b] = STAMP_RESET;
        seq_mode = MODE_IDLE;
        seq_prior = MODE_WAIT;
        seq_after_release = MODE_IDLE;
        seq_held = BTN_STOP;
        seq_target = TARGET_RESET;
    endtask

    task automatic enter_release_wait(input mode_t next_mode, input btn_t button);
        seq_after_release = next_mode;
        seq_held = button;
        seq_mode = MODE_WAIT;
    endtask

    // One tick of the sequencer: debounce the buttons, then step the mode machine.
    task automatic advance_sequencer(input logic [2:0] levels, input logic [TIME_W-1:0] now,
                                     input logic [COUNT_W-1:0] flow, output result_t res);
        int                 b;
        logic [TIME_W-1:0]  elapsed;
        logic [COUNT_W-1:0] flow_used;
        mode_t              start_mode;
        logic               entry;
        logic               restart;
        restart = 1'b0;

        // A timer that reads below the change time counts double the distance.
        for (b = 0; b < BUTTON_COUNT; b++) begin
            if (levels[b] != raw_lvl[b]) begin
                change_time[b] = now;
                raw_lvl[b] = levels[b];
            end
            if (now < change_time[b])
                elapsed = (change_time[b] - now) << 1;
            else
                elapsed = now - change_time[b];
            if (elapsed > TIME_W'(db_limit))
                deb_lvl[b] = levels[b];
        end

        start_mode = seq_mode;
        entry = (seq_mode != seq_prior);
        // The flow counter restarts on the entry tick, so the count seen then is zero.
        flow_used = entry ? '0 : flow;

        // Later rules override earlier ones; stop has the last word.
        case (seq_mode)
            MODE_IDLE: begin
                if (deb_lvl[BTN_MODE]) enter_release_wait(MODE_FILLMENU, BTN_MODE);
                if (deb_lvl[BTN_FILL]) enter_release_wait(MODE_FLOW, BTN_FILL);
            end
            MODE_FLOW: begin
                if (entry) begin
                    seq_prior = seq_mode;
                    restart = 1'b1;
                end
                if (deb_lvl[BTN_STOP]) enter_release_wait(MODE_IDLE, BTN_STOP);
            end
            MODE_FILL: begin
                if (entry) begin
                    seq_prior = seq_mode;
                    restart = 1'b1;
                end
                if (flow_used > seq_target) seq_mode = MODE_FILLMENU;
                if (deb_lvl[BTN_STOP]) enter_release_wait(MODE_IDLE, BTN_STOP);
            end
            MODE_FILLMENU: begin
                if (entry) seq_prior = seq_mode;
                if (deb_lvl[BTN_MODE]) enter_release_wait(MODE_PROGMENU, BTN_MODE);
                if (deb_lvl[BTN_FILL]) enter_release_wait(MODE_FILL, BTN_FILL);
                if (deb_lvl[BTN_STOP]) enter_release_wait(MODE_IDLE, BTN_STOP);
            end
            MODE_PROGMENU: begin
                if (entry) seq_prior = seq_mode;
                if (deb_lvl[BTN_MODE]) enter_release_wait(MODE_FILLMENU, BTN_MODE);
                if (deb_lvl[BTN_FILL]) enter_release_wait(MODE_PROG, BTN_FILL);
                if (deb_lvl[BTN_STOP]) enter_release_wait(MODE_IDLE, BTN_STOP);
            end
            MODE_PROG: begin
                if (entry) begin
                    seq_prior = seq_mode;
                    restart = 1'b1;
                end
                if (deb_lvl[BTN_STOP]) begin
                    seq_target = flow_used;
                    enter_release_wait(MODE_PROGMENU, BTN_STOP);
                end
            end
            MODE_WAIT: begin
                if (!deb_lvl[seq_held]) begin
                    seq_mode = seq_after_release;
                    seq_prior = MODE_WAIT;
                end
            end
            default: begin
            end
        endcase

        res.pump_on = (start_mode == MODE_FLOW || start_mode == MODE_FILL ||
                       start_mode == MODE_PROG) && (seq_mode == start_mode);
        res.restart_flow = restart;
        res.mode_code = seq_mode;
        res.target_count = seq_target;
    endtask

    // Predict on every input transfer and check every result transfer.
    always @(posedge aclk) begin
        result_t got_res;
        result_t want_res;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                advance_sequencer(s_tdata[2:0], s_tdata[34:3], s_tdata[66:35], want_res);
                pending_results.push_back(want_res);
            end
            if (m_tvalid && m_tready) begin
                got_res = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none outstanding",
                                              results_checked));
                end else begin
                    want_res = pending_results.pop_front();
                    if (got_res.pump_on !== want_res.pump_on)
                        report_mismatch($sformatf("result %0d pump_on: expected %0d, got %0d",
                            results_checked, want_res.pump_on, got_res.pump_on));
                    if (got_res.restart_flow !== want_res.restart_flow)
                        report_mismatch($sformatf(
                            "result %0d restart_flow: expected %0d, got %0d",
                            results_checked, want_res.restart_flow, got_res.restart_flow));
                    if (got_res.mode_code !== want_res.mode_code)
                        report_mismatch($sformatf(
                            "result %0d mode_code: expected %0d, got %0d",
                            results_checked, want_res.mode_code, got_res.mode_code));
                    if (got_res.target_count !== want_res.target_count)
                        report_mismatch($sformatf(
                            "result %0d target_count: expected %0h, got %0h",
                            results_checked, want_res.target_count, got_res.target_count));
                end
                results_checked++;
            end
        end
    end

    // Offer one tick after a random idle gap and hold it until the transfer.
    task automatic send_tick(input logic [2:0] levels, input logic [TIME_W-1:0] ktime,
                             input logic [COUNT_W-1:0] flow);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, flow, ktime, levels};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        ticks_sent++;
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_debounce_limit(input logic [LIMIT_W-1:0] value);
        wait_results_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        db_limit = value;
    endtask

    // Directed ticks with the timer stepping past the reset debounce limit.
    task automatic drive_levels(input logic [2:0] levels, input logic [COUNT_W-1:0] flow,
                                input int count);
        repeat (count) begin
            key_clock += 32'd7;
            send_tick(levels, key_clock, flow);
        end
    endtask

    // One tick with a random timer step and a flow count mostly random, sometimes near the fill target.
    task automatic send_random_tick(input logic [2:0] levels, input int step_max);
        logic [COUNT_W-1:0] flow;
        int                 pick;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 3)
            key_clock = $urandom;
        else
            key_clock += $urandom_range(0, step_max);
        if (pick < 80)
            flow = $urandom_range(0, 5000);
        else if (pick < 95)
            flow = seq_target + $urandom_range(0, 2) - 1;
        else
            flow = $urandom;
        send_tick(levels, key_clock, flow);
    endtask

    // A press held for a while and then released; now and then raw noise instead.
    task automatic send_gesture();
        logic [2:0] press;
        int         step_max;
        step_max = int'(db_limit) + 3;
        if ($urandom_range(99) < 80) begin
            if ($urandom_range(99) < 75)
                press = 3'b001 << $urandom_range(0, 2);
            else
                press = 3'($urandom_range(1, 7));
            repeat ($urandom_range(1, 5)) send_random_tick(press, step_max);
            repeat ($urandom_range(1, 5)) send_random_tick(LV_NONE, step_max);
        end else begin
            repeat ($urandom_range(1, 6)) send_random_tick(3'($urandom_range(0, 7)), step_max);
        end
    endtask

    // Walk every mode at the reset debounce limit, with the timer crossing its wrap.
    task automatic test_directed_modes();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        key_clock = 32'hFFFF_FFFF - 32'd70;
        // Timer below the reset change time.
        send_tick(LV_NONE, 32'h0, 32'hFFFF_FFFF);
        // Mode and fill together in idle: fill wins and free flow is next.
        drive_levels(LV_MODE | LV_FILL, 32'h0, 2);
        // Free flow is entered while stop is already down.
        drive_levels(LV_STOP, 32'hFFFF_FFFF, 3);
        drive_levels(LV_MODE, 32'h0, 3);
        drive_levels(LV_FILL, 32'h0, 3);
        drive_levels(LV_NONE, 32'h0, 2);
        // Entry tick of fill ignores the flow count; the next tick completes the fill.
        drive_levels(LV_NONE, 32'hFFFF_FFFF, 2);
        drive_levels(LV_MODE, 32'h0, 2);
        drive_levels(LV_FILL, 32'h0, 3);
        // Stop on the entry tick of program stores a zero target.
        drive_levels(LV_STOP, 32'hFFFF_FFFF, 3);
        drive_levels(LV_NONE, 32'hFFFF_FFFF, 2);
    endtask

    task automatic test_random_ticks(input logic [LIMIT_W-1:0] limit, input int idle_pct,
                                     input int stall_pct, input int count);
        int first;
        write_debounce_limit(limit);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        first = ticks_sent;
        while (ticks_sent - first < count)
            send_gesture();
    endtask

    // Long receiver hold-off while ticks keep coming, a full drain, then a shorter hold-off with sparse ticks.
    task automatic test_backpressure();
        int first;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 250;
        first = ticks_sent;
        while (ticks_sent - first < 60)
            send_gesture();
        wait_results_drained();
        send_idle_pct = 65;
        hold_request = 40;
        first = ticks_sent;
        while (ticks_sent - first < 30)
            send_gesture();
    endtask

    initial begin
        reset_sequencer_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_modes();
        test_random_ticks(16'd0, 0, 0, 350);
        test_random_ticks(16'hFFFF, 65, 0, 350);
        test_random_ticks(16'($urandom_range(1, 400)), 0, 65, 350);
        test_random_ticks(16'd5, 10, 10, 350);
        test_backpressure();

        wait_results_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
